// ===== sv/bcu_pkg.sv =====
`timescale 1ns / 1ps
package bcu_pkg;

  localparam int CoordW  = 16;
  localparam int WeightW = 24;

  typedef struct packed {
    logic signed [CoordW-1:0] query_x;
    logic signed [CoordW-1:0] query_y;
    logic signed [CoordW-1:0] vert1_x;
    logic signed [CoordW-1:0] vert1_y;
    logic signed [CoordW-1:0] vert2_x;
    logic signed [CoordW-1:0] vert2_y;
    logic signed [CoordW-1:0] vert3_x;
    logic signed [CoordW-1:0] vert3_y;
  } in_beat_t;

  typedef struct packed {
    logic [WeightW-1:0] weight_first;
    logic [WeightW-1:0] weight_second;
    logic [WeightW-1:0] weight_third;
    logic               degenerate;
    logic               clipped;
  } out_beat_t;

endpackage

// ===== sv/bcu_front.sv =====
`timescale 1ns / 1ps
module bcu_front #(
  parameter int COORD_BITS = 16,
  parameter int AW = 2 * COORD_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  bcu_pkg::in_beat_t    in_beat,
  output logic                 in_hold,
  output logic                 out_valid,
  input  logic                 out_hold,
  output logic [AW-1:0]        tri_area,
  output logic [2:0][AW-1:0]   sub_area
);
  import bcu_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2 * CB + 2;
  localparam int XW = 2 * CB + 3;

  logic [2:0] v_r;
  logic [2:0] busy;

  logic signed [CB-1:0] px, py, x1, y1, x2, y2, x3, y3;
  logic signed [DW-1:0] d_nxt [10];
  logic signed [DW-1:0] d_r [10];
  logic signed [PW-1:0] p_r [8];
  logic signed [XW-1:0] c [4];
  logic [3:0][AW-1:0]   a_r;

  function automatic logic signed [CB-1:0] coord(input logic [CoordW-1:0] raw);
    logic [CB+CoordW-1:0] z;
    z = {{CB{1'b0}}, raw};
    return $signed(z[CB-1:0]);
  endfunction

  function automatic logic signed [DW-1:0] sub(input logic signed [CB-1:0] a,
                                               input logic signed [CB-1:0] b);
    return DW'(a) - DW'(b);
  endfunction

  always_comb begin
    px = coord(in_beat.query_x);
    py = coord(in_beat.query_y);
    x1 = coord(in_beat.vert1_x);
    y1 = coord(in_beat.vert1_y);
    x2 = coord(in_beat.vert2_x);
    y2 = coord(in_beat.vert2_y);
    x3 = coord(in_beat.vert3_x);
    y3 = coord(in_beat.vert3_y);
    d_nxt[0] = sub(x2, x1);
    d_nxt[1] = sub(y2, y1);
    d_nxt[2] = sub(x3, x1);
    d_nxt[3] = sub(y3, y1);
    d_nxt[4] = sub(x2, px);
    d_nxt[5] = sub(y2, py);
    d_nxt[6] = sub(x3, px);
    d_nxt[7] = sub(y3, py);
    d_nxt[8] = sub(px, x1);
    d_nxt[9] = sub(py, y1);
  end

  // stage 3 holds |T|, |A1|, |A2|, |A3|
  always_comb begin
    c[0] = XW'(p_r[0]) - XW'(p_r[1]);
    c[1] = XW'(p_r[2]) - XW'(p_r[3]);
    c[2] = XW'(p_r[4]) - XW'(p_r[5]);
    c[3] = XW'(p_r[6]) - XW'(p_r[7]);
  end

  // a stage blocks only when it is full and the next one blocks
  assign busy[2] = v_r[2] & out_hold;
  assign busy[1] = v_r[1] & busy[2];
  assign busy[0] = v_r[0] & busy[1];
  assign in_hold = busy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (!busy[0]) v_r[0] <= in_valid;
      if (!busy[1]) v_r[1] <= v_r[0];
      if (!busy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!busy[0]) begin
      for (int i = 0; i < 10; i++) d_r[i] <= d_nxt[i];
    end
    if (!busy[1]) begin
      p_r[0] <= PW'(d_r[0]) * PW'(d_r[3]);
      p_r[1] <= PW'(d_r[1]) * PW'(d_r[2]);
      p_r[2] <= PW'(d_r[4]) * PW'(d_r[7]);
      p_r[3] <= PW'(d_r[5]) * PW'(d_r[6]);
      p_r[4] <= PW'(d_r[8]) * PW'(d_r[3]);
      p_r[5] <= PW'(d_r[9]) * PW'(d_r[2]);
      p_r[6] <= PW'(d_r[0]) * PW'(d_r[9]);
      p_r[7] <= PW'(d_r[1]) * PW'(d_r[8]);
    end
    if (!busy[2]) begin
      for (int i = 0; i < 4; i++) begin
        a_r[i] <= c[i][XW-1] ? AW'(-c[i]) : AW'(c[i]);
      end
    end
  end

  assign out_valid   = v_r[2];
  assign tri_area    = a_r[0];
  assign sub_area[0] = a_r[1];
  assign sub_area[1] = a_r[2];
  assign sub_area[2] = a_r[3];

endmodule

// ===== sv/bcu_div_cell.sv =====
`timescale 1ns / 1ps
module bcu_div_cell #(
  parameter int AW = 33,
  parameter int QW = 24,
  parameter int SW = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_hold,
  output logic                 out_valid,
  input  logic                 out_hold,
  input  logic [AW-1:0]        t_in,
  input  logic [2:0][AW-1:0]   r_in,
  input  logic [2:0][QW-1:0]   n_in,
  input  logic [2:0][QW-1:0]   q_in,
  input  logic [SW-1:0]        side_in,
  output logic [AW-1:0]        t_out,
  output logic [2:0][AW-1:0]   r_out,
  output logic [2:0][QW-1:0]   n_out,
  output logic [2:0][QW-1:0]   q_out,
  output logic [SW-1:0]        side_out
);
  import bcu_pkg::*;

  logic                v_r;
  logic [AW-1:0]       t_r;
  logic [2:0][AW-1:0]  r_r;
  logic [2:0][QW-1:0]  n_r;
  logic [2:0][QW-1:0]  q_r;
  logic [SW-1:0]       side_r;
  logic [AW:0]         r2 [3];
  logic [2:0]          ge;
  logic [2:0][AW-1:0]  r_nxt;

  // one restoring step per lane: bring down the next numerator bit
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r2[i] = {r_in[i], n_in[i][QW-1]};
      ge[i] = r2[i] >= {1'b0, t_in};
      r_nxt[i] = ge[i] ? AW'(r2[i] - {1'b0, t_in}) : AW'(r2[i]);
    end
  end

  assign in_hold = v_r & out_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!in_hold) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_hold) begin
      t_r    <= t_in;
      r_r    <= r_nxt;
      side_r <= side_in;
      for (int i = 0; i < 3; i++) begin
        n_r[i] <= {n_in[i][QW-2:0], 1'b0};
        q_r[i] <= {q_in[i][QW-2:0], ge[i]};
      end
    end
  end

  assign out_valid = v_r;
  assign t_out     = t_r;
  assign r_out     = r_r;
  assign n_out     = n_r;
  assign q_out     = q_r;
  assign side_out  = side_r;

endmodule

// ===== sv/barycentric_coordinates_unit.sv =====
`timescale 1ns / 1ps
// Barycentric weights of a query point against a triangle, by area ratio.
// Input channel: in_valid / in_stall carry one beat of eight signed
// coordinates (the point and three vertices); the low COORD_BITS bits count.
// Output channel: out_valid / out_stall carry one beat of three unsigned
// Q8.FRAC_BITS weights plus the degenerate and clipped flags.
// Each input beat gives exactly one output beat, in order.
// Throughput: one beat per cycle, with no gaps, while out_stall stays low.
// Pipeline: 3 front stages (differences, products, cross magnitudes),
// then 8+FRAC_BITS division cells at one quotient bit each, then the
// output register.
// The division chain sets the latency; every stage holds one beat.
// Reset (rst_n low at a clock edge) empties every stage; nothing is in
// flight afterwards.
// When out_stall is high the output beat holds; stages behind it keep
// filling any empty slots, and in_stall rises once the chain is full.
module barycentric_coordinates_unit #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bcu_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output bcu_pkg::out_beat_t  out_beat
);
  import bcu_pkg::*;

  localparam int AW = 2 * COORD_BITS + 1;
  localparam int QW = 8 + FRAC_BITS;
  localparam int NC = QW;
  localparam int SW = 4;

  logic                f_valid, f_hold;
  logic [AW-1:0]       f_t;
  logic [2:0][AW-1:0]  f_a;

  logic [NC:0]                c_valid;
  logic [NC:0]                c_hold;
  logic [NC:0][AW-1:0]        c_t;
  logic [NC:0][2:0][AW-1:0]   c_r;
  logic [NC:0][2:0][QW-1:0]   c_n;
  logic [NC:0][2:0][QW-1:0]   c_q;
  logic [NC:0][SW-1:0]        c_side;

  logic                o_valid_r;
  out_beat_t           o_beat_r;
  logic                o_hold;
  logic [2:0]          sat;
  logic [2:0][QW-1:0]  w;
  logic [QW+WeightW-1:0] wext [3];
  logic                deg;

  bcu_front #(.COORD_BITS(COORD_BITS), .AW(AW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_beat  (in_beat),
    .in_hold  (in_stall),
    .out_valid(f_valid),
    .out_hold (f_hold),
    .tri_area (f_t),
    .sub_area (f_a)
  );

  // seed the chain: quotient of (a << FRAC_BITS) / t, first 8+FRAC_BITS bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat[i]    = (f_a[i] >> 8) >= f_t;
      c_r[0][i] = f_a[i] >> 8;
      c_n[0][i] = {f_a[i][7:0], {FRAC_BITS{1'b0}}};
      c_q[0][i] = '0;
    end
    c_t[0]    = f_t;
    c_side[0] = {f_t == '0, sat};
    c_valid[0] = f_valid;
    f_hold    = c_hold[0];
  end

  for (genvar k = 0; k < NC; k++) begin : g_cell
    bcu_div_cell #(.AW(AW), .QW(QW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (c_valid[k]),
      .in_hold  (c_hold[k]),
      .out_valid(c_valid[k+1]),
      .out_hold (c_hold[k+1]),
      .t_in     (c_t[k]),
      .r_in     (c_r[k]),
      .n_in     (c_n[k]),
      .q_in     (c_q[k]),
      .side_in  (c_side[k]),
      .t_out    (c_t[k+1]),
      .r_out    (c_r[k+1]),
      .n_out    (c_n[k+1]),
      .q_out    (c_q[k+1]),
      .side_out (c_side[k+1])
    );
  end

  assign c_hold[NC] = o_hold;
  assign o_hold     = o_valid_r & out_stall;

  always_comb begin
    deg = c_side[NC][3];
    for (int i = 0; i < 3; i++) begin
      w[i]    = c_side[NC][i] ? {QW{1'b1}} : c_q[NC][i];
      wext[i] = {{WeightW{1'b0}}, w[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (!o_hold) begin
      o_valid_r <= c_valid[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (!o_hold) begin
      o_beat_r.weight_first  <= deg ? '0 : wext[0][WeightW-1:0];
      o_beat_r.weight_second <= deg ? '0 : wext[1][WeightW-1:0];
      o_beat_r.weight_third  <= deg ? '0 : wext[2][WeightW-1:0];
      o_beat_r.degenerate    <= deg;
      o_beat_r.clipped       <= !deg && (c_side[NC][2:0] != 3'b000);
    end
  end

  assign out_valid = o_valid_r;
  assign out_beat  = o_beat_r;

endmodule

// ===== tb/tb_barycentric_coordinates_unit.sv =====
`timescale 1ns / 1ps
module tb_barycentric_coordinates_unit;
  import bcu_pkg::*;

  localparam int LATENCY = 28;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_beat;

  out_beat_t weights_pending[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;

  barycentric_coordinates_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

  always #10 clk = ~clk;

  // |(b-a) x (c-a)|, exact at 64 bits
  function automatic longint unsigned cross_mag(longint ax, longint ay, longint bx,
                                                longint by, longint cx, longint cy);
    longint p;
    p = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    return p < 0 ? -p : p;
  endfunction

  function automatic logic [WeightW-1:0] area_ratio(longint unsigned a,
                                                    longint unsigned t,
                                                    ref logic clip);
    if ((a >> 8) >= t) begin
      clip = 1'b1;
      return '1;
    end
    return WeightW'((a << 16) / t);
  endfunction

  function automatic out_beat_t predict_weights(in_beat_t b);
    out_beat_t r;
    longint px, py, x1, y1, x2, y2, x3, y3;
    longint unsigned t;
    logic clip;
    px = longint'(b.query_x); py = longint'(b.query_y);
    x1 = longint'(b.vert1_x); y1 = longint'(b.vert1_y);
    x2 = longint'(b.vert2_x); y2 = longint'(b.vert2_y);
    x3 = longint'(b.vert3_x); y3 = longint'(b.vert3_y);
    r = '0;
    clip = 1'b0;
    t = cross_mag(x1, y1, x2, y2, x3, y3);
    if (t == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    r.weight_first = area_ratio(cross_mag(px, py, x2, y2, x3, y3), t, clip);
    r.weight_second = area_ratio(cross_mag(x1, y1, px, py, x3, y3), t, clip);
    r.weight_third = area_ratio(cross_mag(x1, y1, x2, y2, px, py), t, clip);
    r.clipped = clip;
    return r;
  endfunction

  task automatic queue_expected(out_beat_t w);
    weights_pending.insert(weights_pending.size(), w);
  endtask

  // valid stays high between back-to-back beats; drop it only while idling
  task automatic send_triangle(in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    queue_expected(predict_weights(b));
  endtask

  task automatic send_coords(int qx, int qy, int ax, int ay, int bx, int by,
                             int cx, int cy);
    in_beat_t b;
    b.query_x = CoordW'(qx); b.query_y = CoordW'(qy);
    b.vert1_x = CoordW'(ax); b.vert1_y = CoordW'(ay);
    b.vert2_x = CoordW'(bx); b.vert2_y = CoordW'(by);
    b.vert3_x = CoordW'(cx); b.vert3_y = CoordW'(cy);
    send_triangle(b);
  endtask

  function automatic in_beat_t random_triangle();
    in_beat_t b;
    int span;
    int cx, cy;
    b = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(3))
      0: ;
      1: begin
        // small triangle near a random center, point around it
        span = 1 << $urandom_range(12);
        cx = int'($urandom_range(60000)) - 30000;
        cy = int'($urandom_range(60000)) - 30000;
        b.vert1_x = CoordW'(cx + int'($urandom_range(span)));
        b.vert1_y = CoordW'(cy + int'($urandom_range(span)));
        b.vert2_x = CoordW'(cx + int'($urandom_range(span)));
        b.vert2_y = CoordW'(cy + int'($urandom_range(span)));
        b.vert3_x = CoordW'(cx + int'($urandom_range(span)));
        b.vert3_y = CoordW'(cy + int'($urandom_range(span)));
        b.query_x = CoordW'(cx + int'($urandom_range(span)));
        b.query_y = CoordW'(cy + int'($urandom_range(span)));
      end
      2: begin
        // collinear vertices
        b.vert2_x = b.vert1_x; b.vert2_y = b.vert1_y;
        if ($urandom_range(1)) begin
          b.vert3_x = b.vert1_x; b.vert3_y = CoordW'($urandom);
        end
      end
      default: begin
        // point on a vertex
        b.query_x = b.vert2_x; b.query_y = b.vert2_y;
      end
    endcase
    return b;
  endfunction

  always @(posedge clk) begin
    out_stall <= (hold_off > 0) || ($urandom_range(99) < stall_pct);
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (weights_pending.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, out_beat);
        errors++;
      end else begin
        want = weights_pending.pop_front();
        if (out_beat.weight_first !== want.weight_first)
          $display("%0t: weight_first exp %h got %h", $time, want.weight_first,
                   out_beat.weight_first);
        if (out_beat.weight_second !== want.weight_second)
          $display("%0t: weight_second exp %h got %h", $time, want.weight_second,
                   out_beat.weight_second);
        if (out_beat.weight_third !== want.weight_third)
          $display("%0t: weight_third exp %h got %h", $time, want.weight_third,
                   out_beat.weight_third);
        if (out_beat.degenerate !== want.degenerate)
          $display("%0t: degenerate exp %b got %b", $time, want.degenerate,
                   out_beat.degenerate);
        if (out_beat.clipped !== want.clipped)
          $display("%0t: clipped exp %b got %b", $time, want.clipped, out_beat.clipped);
        if (out_beat !== want) errors++;
      end
    end
  end

  // watchdog: count cycles with no beat accepted on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("barycentric_coordinates_unit test failed");
      $finish;
    end
  end

  task automatic drain_results();
    in_valid <= 1'b0;
    while (weights_pending.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_coords(0, 0, 0, 0, 65536 - 1, 0, 0, 1);
    send_coords(1, 1, 0, 0, 4, 0, 0, 4);
    send_coords(0, 0, 0, 0, 4, 0, 0, 4);
    send_coords(5, 5, 5, 5, 5, 5, 5, 5);
    send_coords(3, 3, 0, 0, 2, 2, 7, 7);
    send_coords(-32768, -32768, -32768, -32768, 32767, -32768, -32768, 32767);
    send_coords(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
    send_coords(32767, 32767, 0, 0, 1, 0, 0, 1);
    send_coords(-32768, 32767, 0, 0, 1, 0, 0, 1);
    send_coords(10000, 0, 0, 0, 1, 0, 0, 1);
    send_coords(1, 2, 0, 0, 3, 0, 0, 3);
    send_coords(100, 100, -32768, 32767, 32767, -32768, 0, 0);
    send_coords(-1, -1, -1, -1, -1, -1, -1, -1);
    send_coords(255, 0, 0, 0, 1, 0, 0, 1);
    send_coords(256, 0, 0, 0, 1, 0, 0, 1);
    send_coords(32767, -32768, 32767, -32768, -32768, 32767, 0, 0);
  endtask

  task automatic test_random(int count, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    stall_pct = r_pct;
    repeat (count) send_triangle(random_triangle());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 3 * LATENCY;
    repeat (60) send_triangle(random_triangle());
    drain_results();
    repeat (20) send_triangle(random_triangle());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 63, 0);
    test_random(300, 0, 63);
    test_random(220, 7, 7);
    test_backpressure();
    drain_results();
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) $display("barycentric_coordinates_unit test passed");
    else $display("barycentric_coordinates_unit test failed");
    $finish;
  end

endmodule
